[rtl/core/tsm_pkg.sv]
// Shared types, opcodes and constants of the tagged stack machine core.
`timescale 1ns / 1ps
`default_nettype none
package tsm_pkg;

   localparam int STACK_DEPTH_DEF   = 256;
   localparam int CELL_BITS_DEF     = 32;
   localparam int TAG_BITS_DEF      = 4;
   localparam int SPECIAL_SLOTS_DEF = 128;
   localparam int CONTEXT_SLOTS_DEF = 16;

   localparam logic [5:0] OP_PUSH    = 6'd0;
   localparam logic [5:0] OP_DUP     = 6'd1;
   localparam logic [5:0] OP_DROP    = 6'd2;
   localparam logic [5:0] OP_SWAP    = 6'd3;
   localparam logic [5:0] OP_OVER    = 6'd4;
   localparam logic [5:0] OP_NIP     = 6'd5;
   localparam logic [5:0] OP_2DROP   = 6'd6;
   localparam logic [5:0] OP_2NIP    = 6'd7;
   localparam logic [5:0] OP_2DUP    = 6'd8;
   localparam logic [5:0] OP_3DROP   = 6'd9;
   localparam logic [5:0] OP_ROT     = 6'd10;
   localparam logic [5:0] OP_NROT    = 6'd11;
   localparam logic [5:0] OP_PICK    = 6'd12;
   localparam logic [5:0] OP_DUPD    = 6'd13;
   localparam logic [5:0] OP_SWAPD   = 6'd14;
   localparam logic [5:0] OP_EQ      = 6'd15;
   localparam logic [5:0] OP_BOTHFIX = 6'd16;
   localparam logic [5:0] OP_LT      = 6'd17;
   localparam logic [5:0] OP_LE      = 6'd18;
   localparam logic [5:0] OP_GT      = 6'd19;
   localparam logic [5:0] OP_GE      = 6'd20;
   localparam logic [5:0] OP_ADD     = 6'd21;
   localparam logic [5:0] OP_SUB     = 6'd22;
   localparam logic [5:0] OP_MUL     = 6'd23;
   localparam logic [5:0] OP_AND     = 6'd24;
   localparam logic [5:0] OP_OR      = 6'd25;
   localparam logic [5:0] OP_XOR     = 6'd26;
   localparam logic [5:0] OP_NOT     = 6'd27;
   localparam logic [5:0] OP_SHIFT   = 6'd28;
   localparam logic [5:0] OP_RSVD    = 6'd29;
   localparam logic [5:0] OP_TAG     = 6'd30;
   localparam logic [5:0] OP_SPGET   = 6'd31;
   localparam logic [5:0] OP_SPSET   = 6'd32;
   localparam logic [5:0] OP_CXGET   = 6'd33;
   localparam logic [5:0] OP_CXSET   = 6'd34;

   localparam logic [1:0] CSR_TRUE  = 2'd0;
   localparam logic [1:0] CSR_FALSE = 2'd1;
   localparam logic [1:0] CSR_FTAG  = 2'd2;

   typedef enum logic [1:0] {
      STAT_OK    = 2'd0,
      STAT_UNDER = 2'd1,
      STAT_OVER  = 2'd2,
      STAT_INDEX = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SPILL,
      ST_TREAD,
      ST_FILL,
      ST_FILLW,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic [5:0]  req_type;
      logic [31:0] literal_cell;
   } req_type;

   typedef struct packed {
      status_type  status;
      logic [31:0] top_cell;
      logic [31:0] second_cell;
      logic [8:0]  stack_depth;
   } rsp_type;

   // cells that an operation needs on the stack
   function automatic logic [1:0] op_need(input logic [5:0] op);
      logic [1:0] n;
      n = 2'd0;
      case (op) inside
         OP_DUP, OP_DROP, OP_NOT, OP_TAG, OP_SPGET, OP_CXGET: n = 2'd1;
         OP_2NIP, OP_3DROP, OP_ROT, OP_NROT, OP_PICK, OP_SWAPD: n = 2'd3;
         [OP_SWAP:OP_2DROP], OP_2DUP, OP_DUPD, [OP_EQ:OP_XOR], OP_SHIFT,
         OP_SPSET, OP_CXSET: n = 2'd2;
         default: n = 2'd0;
      endcase
      return n;
   endfunction

   // cells that an operation adds to the stack; zero where it does not grow it
   function automatic logic [1:0] op_grow(input logic [5:0] op);
      logic [1:0] g;
      g = 2'd0;
      case (op) inside
         OP_PUSH, OP_DUP, OP_OVER, OP_PICK, OP_DUPD: g = 2'd1;
         OP_2DUP: g = 2'd2;
         default: g = 2'd0;
      endcase
      return g;
   endfunction

endpackage
`default_nettype wire

[rtl/core/tagged_stack_machine_core_unit.sv]
// Tagged stack machine core: top three cells in registers, the rest in a stack memory.
// Flow: an accepted operation goes from IDLE to DONE, where the result is registered; table reads
// pass through TREAD, the second spill of 2dup through SPILL, and refilling cached cells after a pop
// passes through FILL and FILLW for each cell. No new operation is taken until the core is back in
// IDLE, so spills, refills, table reads and a stalled result register hold the input off meanwhile.
// Reset: stack empties at once; then a clearing pass zeroes every slot of the object tables
// (SPECIAL_SLOTS+CONTEXT_SLOTS of them) while no item is taken.
`timescale 1ns / 1ps
`default_nettype none
module tagged_stack_machine_core_unit #(
   parameter int STACK_DEPTH   = tsm_pkg::STACK_DEPTH_DEF,
   parameter int CELL_BITS     = tsm_pkg::CELL_BITS_DEF,
   parameter int TAG_BITS      = tsm_pkg::TAG_BITS_DEF,
   parameter int SPECIAL_SLOTS = tsm_pkg::SPECIAL_SLOTS_DEF,
   parameter int CONTEXT_SLOTS = tsm_pkg::CONTEXT_SLOTS_DEF
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire tsm_pkg::req_type req_payload,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output tsm_pkg::rsp_type      rsp_payload,
   input  wire logic             csr_write,
   input  wire logic [1:0]       csr_index,
   input  wire logic [31:0]      csr_wdata
);
   import tsm_pkg::*;

   localparam int SPW  = $clog2(STACK_DEPTH + 1);
   localparam int AW   = $clog2(STACK_DEPTH);
   localparam int VB   = CELL_BITS - TAG_BITS;
   localparam int IW   = ((VB > 11) ? VB : 11) + 1;
   localparam int TABN = SPECIAL_SLOTS + CONTEXT_SLOTS;
   localparam int TAW  = (TABN > 1) ? $clog2(TABN) : 1;

   state_type            state_ff, state_in;
   logic [SPW-1:0]       sp_ff, sp_in;
   logic [CELL_BITS-1:0] c_ff [3];
   logic [CELL_BITS-1:0] c_in [3];
   status_type           stat_ff, stat_in;
   logic [1:0]           slot_ff, slot_in;
   logic [AW-1:0]        spa_ff, spa_in;
   logic [CELL_BITS-1:0] spd_ff, spd_in;
   logic [TAW-1:0]       clr_ff, clr_in;
   rsp_type              rsp_ff, rsp_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [31:0]          true_ff, false_ff;
   logic [3:0]           ftag_ff;

   logic [CELL_BITS-1:0] stk_mem [STACK_DEPTH];
   logic [CELL_BITS-1:0] stk_rdata_ff;
   logic                 stk_we;
   logic [AW-1:0]        stk_waddr, stk_raddr;
   logic [CELL_BITS-1:0] stk_wdata;
   logic [CELL_BITS-1:0] tab_mem [TABN];
   logic [CELL_BITS-1:0] tab_rdata_ff;
   logic                 tab_we;
   logic [TAW-1:0]       tab_waddr, tab_raddr;
   logic [CELL_BITS-1:0] tab_wdata;

   // operand views
   logic [TAG_BITS-1:0]  ft;
   logic [VB-1:0]        xv, yv, nv, r_val, namt;
   logic signed [VB-1:0] xs, ys;
   logic [CELL_BITS-1:0] tcell, fcell, r_cell;
   logic [IW-1:0]        n_ext;
   logic                 spec_ok, ctx_ok;

   // decode results
   logic [1:0]           x_need, x_grow, x_fill, x_spill;
   logic [SPW:0]         x_reach;
   logic [SPW-1:0]       x_nsp;
   logic [CELL_BITS-1:0] x_n [3];
   status_type           x_stat;
   logic                 x_tread, x_twrite;
   logic [TAW-1:0]       x_taddr;

   assign ft    = TAG_BITS'(ftag_ff);
   assign xv    = c_ff[1][CELL_BITS-1:TAG_BITS];
   assign yv    = c_ff[0][CELL_BITS-1:TAG_BITS];
   assign xs    = xv;
   assign ys    = yv;
   assign namt  = VB'(0) - yv;
   assign tcell = CELL_BITS'(true_ff);
   assign fcell = CELL_BITS'(false_ff);
   assign nv    = c_ff[0][CELL_BITS-1:TAG_BITS];
   assign n_ext = IW'(nv);
   assign spec_ok = !nv[VB-1] && (n_ext < IW'(SPECIAL_SLOTS));
   assign ctx_ok  = !nv[VB-1] && (n_ext < IW'(CONTEXT_SLOTS));

   always_comb begin
      r_val  = '0;
      r_cell = '0;
      unique case (req_payload.req_type) inside
         OP_ADD:   r_val = xv + yv;
         OP_SUB:   r_val = xv - yv;
         OP_MUL:   r_val = xv * yv;
         OP_AND:   r_val = xv & yv;
         OP_OR:    r_val = xv | yv;
         OP_XOR:   r_val = xv ^ yv;
         OP_NOT:   r_val = ~yv;
         OP_TAG:   r_val = VB'(c_ff[0][TAG_BITS-1:0]);
         OP_SHIFT: r_val = ys[VB-1] ? VB'(xs >>> namt) : (xv << yv);
         default:  r_val = '0;
      endcase
      unique case (req_payload.req_type) inside
         OP_EQ:      r_cell = (c_ff[1] == c_ff[0]) ? tcell : fcell;
         OP_BOTHFIX: r_cell = (c_ff[1][TAG_BITS-1:0] == ft && c_ff[0][TAG_BITS-1:0] == ft)
                              ? tcell : fcell;
         OP_LT:      r_cell = (xs < ys) ? tcell : fcell;
         OP_LE:      r_cell = (ys < xs) ? fcell : tcell;
         OP_GT:      r_cell = (ys < xs) ? tcell : fcell;
         OP_GE:      r_cell = (xs < ys) ? fcell : tcell;
         default:    r_cell = {r_val, ft};
      endcase
   end

   // operation decode against the cached top cells
   always_comb begin
      x_need   = op_need(req_payload.req_type);
      x_grow   = op_grow(req_payload.req_type);
      x_reach  = {1'b0, sp_ff} + (SPW + 1)'(x_grow);
      x_nsp    = sp_ff;
      x_n[0]   = c_ff[0];
      x_n[1]   = c_ff[1];
      x_n[2]   = c_ff[2];
      x_fill   = 2'd3;
      x_spill  = 2'd0;
      x_stat   = STAT_OK;
      x_tread  = 1'b0;
      x_twrite = 1'b0;
      x_taddr  = TAW'(nv);
      if (req_payload.req_type == OP_CXGET || req_payload.req_type == OP_CXSET) begin
         x_taddr = TAW'(nv) + TAW'(SPECIAL_SLOTS);
      end
      if (req_payload.req_type < 6'd35 && req_payload.req_type != OP_RSVD) begin
         if (sp_ff < SPW'(x_need)) begin
            x_stat = STAT_UNDER;
         end else if (x_reach > (SPW + 1)'(STACK_DEPTH)) begin
            x_stat = STAT_OVER;
         end else begin
            x_spill = x_grow;
            unique case (req_payload.req_type) inside
               OP_PUSH: begin
                  x_n[0] = CELL_BITS'(req_payload.literal_cell);
                  x_n[1] = c_ff[0]; x_n[2] = c_ff[1];
               end
               OP_DUP: begin
                  x_n[1] = c_ff[0]; x_n[2] = c_ff[1];
               end
               OP_DROP: begin
                  x_n[0] = c_ff[1]; x_n[1] = c_ff[2]; x_fill = 2'd2;
               end
               OP_SWAP: begin
                  x_n[0] = c_ff[1]; x_n[1] = c_ff[0];
               end
               OP_OVER: begin
                  x_n[0] = c_ff[1]; x_n[1] = c_ff[0]; x_n[2] = c_ff[1];
               end
               OP_NIP: begin
                  x_n[1] = c_ff[2]; x_fill = 2'd2;
               end
               OP_2DROP: begin
                  x_n[0] = c_ff[2]; x_fill = 2'd1;
               end
               OP_2NIP: x_fill = 2'd1;
               OP_2DUP: begin
                  x_n[2] = c_ff[0];
               end
               OP_3DROP: x_fill = 2'd0;
               OP_ROT, OP_PICK: begin
                  x_n[0] = c_ff[2]; x_n[1] = c_ff[0]; x_n[2] = c_ff[1];
               end
               OP_NROT: begin
                  x_n[0] = c_ff[1]; x_n[1] = c_ff[2]; x_n[2] = c_ff[0];
               end
               OP_DUPD: begin
                  x_n[1] = c_ff[1]; x_n[2] = c_ff[1];
               end
               OP_SWAPD: begin
                  x_n[1] = c_ff[2]; x_n[2] = c_ff[1];
               end
               [OP_EQ:OP_XOR], OP_SHIFT: begin
                  x_n[0] = r_cell; x_n[1] = c_ff[2]; x_fill = 2'd2;
               end
               OP_NOT, OP_TAG: x_n[0] = r_cell;
               OP_SPGET, OP_CXGET: begin
                  if ((req_payload.req_type == OP_SPGET) ? spec_ok : ctx_ok) begin
                     x_tread = 1'b1;
                  end else begin
                     x_stat = STAT_INDEX;
                  end
               end
               OP_SPSET, OP_CXSET: begin
                  if ((req_payload.req_type == OP_SPSET) ? spec_ok : ctx_ok) begin
                     x_twrite = 1'b1;
                     x_n[0]   = c_ff[2];
                     x_fill   = 2'd1;
                  end else begin
                     x_stat = STAT_INDEX;
                  end
               end
               default: x_spill = 2'd0;
            endcase
            if (x_stat == STAT_OK) begin
               unique case (req_payload.req_type) inside
                  OP_DROP, OP_NIP, [OP_EQ:OP_XOR], OP_SHIFT: x_nsp = sp_ff - SPW'(1);
                  OP_2DROP, OP_2NIP, OP_SPSET, OP_CXSET:     x_nsp = sp_ff - SPW'(2);
                  OP_3DROP:                                  x_nsp = sp_ff - SPW'(3);
                  default:                                   x_nsp = SPW'(x_reach);
               endcase
            end
         end
      end
   end

   assign req_stall = (state_ff != ST_IDLE);

   // sequencer
   always_comb begin
      state_in     = state_ff;
      sp_in        = sp_ff;
      c_in[0]      = c_ff[0];
      c_in[1]      = c_ff[1];
      c_in[2]      = c_ff[2];
      stat_in      = stat_ff;
      slot_in      = slot_ff;
      spa_in       = spa_ff;
      spd_in       = spd_ff;
      clr_in       = clr_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      stk_we       = 1'b0;
      stk_waddr    = '0;
      stk_wdata    = '0;
      stk_raddr    = '0;
      tab_we       = 1'b0;
      tab_waddr    = '0;
      tab_wdata    = '0;
      tab_raddr    = x_taddr;
      unique case (state_ff)
         ST_CLEAR: begin
            tab_we    = 1'b1;
            tab_waddr = clr_ff;
            clr_in    = clr_ff + TAW'(1);
            if (clr_ff == TAW'(TABN - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               sp_in   = x_nsp;
               c_in[0] = x_n[0];
               c_in[1] = x_n[1];
               c_in[2] = x_n[2];
               stat_in = x_stat;
               slot_in = x_fill;
               spa_in  = AW'(sp_ff - SPW'(2));
               spd_in  = c_ff[1];
               // third cached cell drops into memory on any operation that grows the stack
               if (x_spill != 2'd0 && sp_ff >= SPW'(3)) begin
                  stk_we    = 1'b1;
                  stk_waddr = AW'(sp_ff - SPW'(3));
                  stk_wdata = c_ff[2];
               end
               if (x_twrite) begin
                  tab_we    = 1'b1;
                  tab_waddr = x_taddr;
                  tab_wdata = c_ff[1];
               end
               if (x_spill == 2'd2) begin
                  state_in = ST_SPILL;
               end else if (x_tread) begin
                  state_in = ST_TREAD;
               end else if (x_fill != 2'd3 && SPW'(x_fill) < x_nsp) begin
                  state_in = ST_FILL;
               end else begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_SPILL: begin
            stk_we    = 1'b1;
            stk_waddr = spa_ff;
            stk_wdata = spd_ff;
            state_in  = ST_DONE;
         end
         ST_TREAD: begin
            c_in[0]  = tab_rdata_ff;
            state_in = ST_DONE;
         end
         ST_FILL: begin
            stk_raddr = AW'(sp_ff - SPW'(1) - SPW'(slot_ff));
            state_in  = ST_FILLW;
         end
         ST_FILLW: begin
            c_in[slot_ff] = stk_rdata_ff;
            slot_in       = slot_ff + 2'd1;
            if (slot_ff < 2'd2 && SPW'(slot_ff) + SPW'(1) < sp_ff) begin
               state_in = ST_FILL;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in       = 1'b1;
               rsp_in.status      = stat_ff;
               rsp_in.top_cell    = (sp_ff >= SPW'(1)) ? 32'(c_ff[0]) : 32'd0;
               rsp_in.second_cell = (sp_ff >= SPW'(2)) ? 32'(c_ff[1]) : 32'd0;
               rsp_in.stack_depth = 9'(sp_ff);
               state_in           = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sp_ff        <= '0;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         true_ff      <= 32'd0;
         false_ff     <= 32'd1;
         ftag_ff      <= 4'd0;
      end else begin
         sp_ff        <= sp_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write) begin
            unique case (csr_index)
               CSR_TRUE:  true_ff  <= csr_wdata;
               CSR_FALSE: false_ff <= csr_wdata;
               CSR_FTAG:  ftag_ff  <= csr_wdata[3:0];
               default:   ftag_ff  <= ftag_ff;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      c_ff[0] <= c_in[0];
      c_ff[1] <= c_in[1];
      c_ff[2] <= c_in[2];
      stat_ff <= stat_in;
      slot_ff <= slot_in;
      spa_ff  <= spa_in;
      spd_ff  <= spd_in;
      rsp_ff  <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (stk_we) begin
         stk_mem[stk_waddr] <= stk_wdata;
      end
      stk_rdata_ff <= stk_mem[stk_raddr];
   end

   always_ff @(posedge clock) begin
      if (tab_we) begin
         tab_mem[tab_waddr] <= tab_wdata;
      end
      tab_rdata_ff <= tab_mem[tab_raddr];
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

`ifndef SYNTHESIS
   a_depth_bound: assert property (@(posedge clock) disable iff (reset)
      sp_ff <= SPW'(STACK_DEPTH))
      else $error("stack depth beyond capacity");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> state_ff != ST_IDLE)
      else $error("accepted transfer did not start work");

   a_fill_slot: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_FILLW |-> slot_ff != 2'd3)
      else $error("refill slot out of range");

   a_result_once: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DONE && state_in == ST_IDLE |=> rsp_valid_ff)
      else $error("finished operation produced no result");
`endif

endmodule
`default_nettype wire

[sim/tagged_stack_machine_core_unit_tb.sv]
// Testbench for the tagged stack machine core: directed and random operation streams.
`timescale 1ns / 1ps
`default_nettype none
module tagged_stack_machine_core_unit_tb;
   import tsm_pkg::*;

   localparam int DEPTH = 256;
   localparam int TB = 4;
   localparam int NSPEC = 128;
   localparam int NCTX = 16;
   localparam int WATCH_LIMIT = 20000;
   localparam int EXP_SLOTS = 1024;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   req_type req_payload = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   rsp_type rsp_payload;
   logic csr_write = 1'b0;
   logic [1:0] csr_index = CSR_TRUE;
   logic [31:0] csr_wdata = '0;

   tagged_stack_machine_core_unit u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_payload(req_payload),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_payload(rsp_payload),
      .csr_write(csr_write), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // machine state mirror
   logic [31:0] m_stack [DEPTH];
   int unsigned m_sp;
   logic [31:0] m_spec [NSPEC];
   logic [31:0] m_ctx [NCTX];
   logic [31:0] m_true, m_false;
   logic [3:0]  m_ftag;

   // expected results, oldest at exp_rd
   rsp_type exp_mem [EXP_SLOTS];
   int exp_wr = 0;
   int exp_rd = 0;
   int errors = 0;
   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   bit hold_off = 1'b0;
   int quiet_cycles = 0;

   function automatic logic signed [63:0] untag(logic [31:0] c);
      logic signed [63:0] v;
      v = {{32{c[31]}}, c};
      return v >>> TB;
   endfunction

   function automatic logic [31:0] retag(logic [63:0] v);
      return {v[27:0], m_ftag};
   endfunction

   function automatic logic [31:0] bool_cell(bit b);
      return b ? m_true : m_false;
   endfunction

   function automatic logic [63:0] shifted(logic signed [63:0] x, logic signed [63:0] s);
      logic [63:0] amt;
      if (s >= 0) return (s >= 64) ? 64'd0 : (x << s);
      amt = -s;
      if (amt > 63) amt = 63;
      return x >>> amt;
   endfunction

   function automatic int unsigned needed(logic [5:0] op);
      case (op)
         OP_DUP, OP_DROP, OP_NOT, OP_TAG, OP_SPGET, OP_CXGET: return 1;
         OP_2NIP, OP_3DROP, OP_ROT, OP_NROT, OP_PICK, OP_SWAPD: return 3;
         OP_PUSH, OP_RSVD: return 0;
         default: return (op <= OP_CXSET) ? 2 : 0;
      endcase
   endfunction

   function automatic int unsigned growth(logic [5:0] op);
      case (op)
         OP_PUSH, OP_DUP, OP_OVER, OP_PICK, OP_DUPD: return 1;
         OP_2DUP: return 2;
         default: return 0;
      endcase
   endfunction

   // applies one operation to the mirror and returns the response it should produce
   function automatic rsp_type execute_op(req_type r);
      rsp_type e;
      logic [5:0] op;
      logic [31:0] a, b, c, res;
      logic signed [63:0] x, y, n;
      int unsigned sp;
      op = r.req_type;
      sp = m_sp;
      e.status = STAT_OK;
      if (op <= OP_CXSET && op != OP_RSVD) begin
         a = sp >= 1 ? m_stack[sp-1] : '0;
         b = sp >= 2 ? m_stack[sp-2] : '0;
         c = sp >= 3 ? m_stack[sp-3] : '0;
         if (sp < needed(op)) e.status = STAT_UNDER;
         else if (sp + growth(op) > DEPTH) e.status = STAT_OVER;
         else if (op >= OP_SPGET) begin
            n = untag(a);
            if (n < 0 || n >= ((op <= OP_SPSET) ? NSPEC : NCTX)) e.status = STAT_INDEX;
            else case (op)
               OP_SPGET: m_stack[sp-1] = m_spec[n];
               OP_SPSET: begin m_spec[n] = b; sp -= 2; end
               OP_CXGET: m_stack[sp-1] = m_ctx[n];
               default: begin m_ctx[n] = b; sp -= 2; end
            endcase
         end else if (op <= OP_SWAPD) begin
            case (op)
               OP_PUSH: begin m_stack[sp] = r.literal_cell; sp++; end
               OP_DUP: begin m_stack[sp] = a; sp++; end
               OP_DROP: sp -= 1;
               OP_SWAP: begin m_stack[sp-1] = b; m_stack[sp-2] = a; end
               OP_OVER: begin m_stack[sp] = b; sp++; end
               OP_NIP: begin m_stack[sp-2] = a; sp -= 1; end
               OP_2DROP: sp -= 2;
               OP_2NIP: begin m_stack[sp-3] = a; sp -= 2; end
               OP_2DUP: begin m_stack[sp] = b; m_stack[sp+1] = a; sp += 2; end
               OP_3DROP: sp -= 3;
               OP_ROT: begin m_stack[sp-3] = b; m_stack[sp-2] = a; m_stack[sp-1] = c; end
               OP_NROT: begin m_stack[sp-3] = a; m_stack[sp-2] = c; m_stack[sp-1] = b; end
               OP_PICK: begin m_stack[sp] = c; sp++; end
               OP_DUPD: begin m_stack[sp-1] = b; m_stack[sp] = a; sp++; end
               default: begin m_stack[sp-3] = b; m_stack[sp-2] = c; end
            endcase
         end else if (op == OP_NOT) begin
            m_stack[sp-1] = retag(~untag(a));
         end else if (op == OP_TAG) begin
            m_stack[sp-1] = retag({60'd0, a[3:0]});
         end else begin
            x = untag(b);
            y = untag(a);
            case (op)
               OP_EQ: res = bool_cell(a == b);
               OP_BOTHFIX: res = bool_cell(a[3:0] == m_ftag && b[3:0] == m_ftag);
               OP_LT: res = bool_cell(x < y);
               OP_LE: res = bool_cell(x <= y);
               OP_GT: res = bool_cell(x > y);
               OP_GE: res = bool_cell(x >= y);
               OP_ADD: res = retag(x + y);
               OP_SUB: res = retag(x - y);
               OP_MUL: res = retag(x * y);
               OP_AND: res = retag(x & y);
               OP_OR: res = retag(x | y);
               OP_XOR: res = retag(x ^ y);
               default: res = retag(shifted(x, y));
            endcase
            m_stack[sp-2] = res;
            sp -= 1;
         end
      end
      m_sp = sp;
      e.top_cell = sp >= 1 ? m_stack[sp-1] : '0;
      e.second_cell = sp >= 2 ? m_stack[sp-2] : '0;
      e.stack_depth = sp[8:0];
      return e;
   endfunction

   // predict on every accepted transfer
   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall) begin
         exp_mem[exp_wr % EXP_SLOTS] = execute_op(req_payload);
         exp_wr++;
      end
   end

   // compare each result transfer with the oldest expectation
   always @(posedge clock) begin
      rsp_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (exp_rd == exp_wr) begin
            $display("%0t: unexpected result %h", $time, rsp_payload);
            errors++;
         end else begin
            e = exp_mem[exp_rd % EXP_SLOTS];
            exp_rd++;
            if (rsp_payload.status != e.status || rsp_payload.top_cell != e.top_cell ||
                rsp_payload.second_cell != e.second_cell ||
                rsp_payload.stack_depth != e.stack_depth) begin
               $display("%0t: mismatch expected st=%0d top=%h sec=%h dep=%0d",
                        $time, e.status, e.top_cell, e.second_cell, e.stack_depth);
               $display("%0t:          actual   st=%0d top=%h sec=%h dep=%0d",
                        $time, rsp_payload.status, rsp_payload.top_cell,
                        rsp_payload.second_cell, rsp_payload.stack_depth);
               errors++;
            end
         end
      end
   end

   always @(posedge clock) begin
      rsp_stall <= hold_off || ($urandom_range(99) < recv_stall_pct);
   end

   // watchdog on transfer-free cycles
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCH_LIMIT) begin
         $display("tagged_stack_machine_core_unit_tb: done, errors");
         $finish;
      end
   end

   // valid stays up after the transfer so that items can follow back to back
   task automatic send_op(logic [5:0] op, logic [31:0] lit);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_payload <= {op, lit};
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (exp_rd != exp_wr) @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   task automatic write_csr(logic [1:0] idx, logic [31:0] val);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_write <= 1'b0;
      case (idx)
         CSR_TRUE: m_true = val;
         CSR_FALSE: m_false = val;
         default: m_ftag = val[3:0];
      endcase
      @(posedge clock);
   endtask

   function automatic logic [31:0] fix(int v);
      return {v[27:0], m_ftag};
   endfunction

   function automatic logic [31:0] rand_cell();
      case ($urandom_range(5))
         0: return 32'h0;
         1: return 32'hFFFF_FFFF;
         2: return 32'h8000_0000 | m_ftag;
         3: return fix($urandom_range(140) - 4);
         4: return fix($urandom_range(70) - 4) ^ ($urandom_range(1) << 0);
         default: return $urandom;
      endcase
   endfunction

   task automatic test_directed();
      send_op(OP_DROP, 0);                 // underflow on empty stack
      send_op(OP_PUSH, 32'hFFFF_FFFF);
      send_op(OP_PUSH, 32'h0);
      send_op(OP_PUSH, 32'h8000_0000);
      for (int op = OP_DUP; op <= OP_SWAPD; op++) send_op(6'(op), 0);
      send_op(OP_PUSH, fix(-200));
      send_op(OP_PUSH, fix(64));
      send_op(OP_SHIFT, 0);                // large left shift
      send_op(OP_PUSH, fix(-70));
      send_op(OP_SHIFT, 0);                // large right shift gives sign
      send_op(OP_PUSH, fix(-1));
      send_op(OP_SPGET, 0);                // bad index
      send_op(OP_RSVD, 0);
      send_op(6'd63, 0);
      wait_drained();
   endtask

   task automatic test_config_sweep();
      write_csr(CSR_TRUE, 32'hFFFF_FFFF);
      write_csr(CSR_FALSE, 32'h0);
      write_csr(CSR_FTAG, 32'hF);
      send_op(OP_PUSH, fix(5));
      send_op(OP_PUSH, fix(-3));
      for (int op = OP_EQ; op <= OP_TAG; op++) begin
         send_op(OP_PUSH, fix($urandom_range(9) - 4));
         send_op(OP_OVER, 0);
         send_op(6'(op), 0);
      end
      wait_drained();
   endtask

   task automatic test_tables();
      for (int i = 0; i < 6; i++) begin
         send_op(OP_PUSH, $urandom);
         send_op(OP_PUSH, fix(i == 0 ? NSPEC - 1 : $urandom_range(NSPEC + 3)));
         send_op(OP_SPSET, 0);
         send_op(OP_PUSH, {28'($urandom_range(NSPEC - 1)), 4'($urandom)});
         send_op(OP_SPGET, 0);
         send_op(OP_PUSH, $urandom);
         send_op(OP_PUSH, fix(i == 0 ? NCTX - 1 : $urandom_range(NCTX + 2)));
         send_op(OP_CXSET, 0);
         send_op(OP_PUSH, fix($urandom_range(NCTX - 1)));
         send_op(OP_CXGET, 0);
      end
      wait_drained();
   endtask

   task automatic test_fill_overflow();
      while (m_sp < DEPTH) send_op(OP_PUSH, $urandom);
      send_op(OP_DUP, 0);
      send_op(OP_2DUP, 0);
      send_op(OP_PUSH, 0);
      while (m_sp >= 3) send_op(OP_3DROP, 0);
      while (m_sp > 0) send_op(OP_DROP, 0);
      wait_drained();
   endtask

   task automatic run_random(int count);
      logic [5:0] op;
      for (int i = 0; i < count; i++) begin
         if (m_sp < 3 || $urandom_range(3) == 0) op = OP_PUSH;
         else if ($urandom_range(19) == 0) op = 6'($urandom_range(63));
         else op = 6'($urandom_range(OP_CXSET));
         if (m_sp > 40 && $urandom_range(1)) op = OP_2DROP;
         send_op(op, (op == OP_PUSH) ? rand_cell() : $urandom);
      end
      wait_drained();
   endtask

   task automatic test_backpressure();
      fork
         begin
            hold_off = 1'b1;
            repeat (200) @(posedge clock);
            hold_off = 1'b0;
         end
         run_random(40);
      join
   endtask

   initial begin
      m_sp = 0;
      m_true = 32'd0;
      m_false = 32'd1;
      m_ftag = 4'd0;
      foreach (m_spec[i]) m_spec[i] = '0;
      foreach (m_ctx[i]) m_ctx[i] = '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_config_sweep();
      test_tables();
      write_csr(CSR_TRUE, $urandom);
      write_csr(CSR_FALSE, $urandom);
      write_csr(CSR_FTAG, $urandom_range(1, 14));
      test_fill_overflow();
      run_random(70);
      send_idle_pct = 49;
      run_random(70);
      send_idle_pct = 0;
      recv_stall_pct = 49;
      write_csr(CSR_FTAG, 32'h0);
      run_random(70);
      send_idle_pct = 9;
      recv_stall_pct = 9;
      run_random(70);
      send_idle_pct = 0;
      recv_stall_pct = 0;
      test_backpressure();
      repeat (20) @(posedge clock);
      if (errors == 0) $display("tagged_stack_machine_core_unit_tb: done, clean");
      else $display("tagged_stack_machine_core_unit_tb: done, errors");
      $finish;
   end

endmodule
`default_nettype wire
